FILE: hw/rtl/cc_pkg.sv
// Package for the canopy clustering block: sizes, register indexes and reset values.
// Used by the top level canopy_clustering; depends on nothing else.
package cc_pkg;

  // Store geometry.
  localparam int MaxPoints = 64;
  localparam int MaxDims   = 4;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  // Point word: four 16-bit coordinates.
  localparam int CoordW = 16;
  localparam int WordW  = CoordW * MaxDims;

  // Distances and thresholds.
  localparam int SqW   = 2 * CoordW;
  localparam int DistW = 34;
  localparam int DimsW = 3;

  // Output field widths.
  localparam int OutIdxW  = 6;
  localparam int OutMaskW = 64;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = DistW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDims  = 2'd0,
    CfgLoose = 2'd1,
    CfgTight = 2'd2
  } cfg_idx_e;

  localparam logic [DimsW-1:0] DimsReset  = 3'd2;
  localparam logic [DistW-1:0] LooseReset = 34'd40000;
  localparam logic [DistW-1:0] TightReset = 34'd10000;

endpackage

FILE: hw/rtl/cc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are undefined until written.
module cc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/canopy_clustering.sv
// Canopy clustering block: point store in RAM, distance pipeline and canopy sequencer.
// Depends on cc_pkg and cc_ram.
//
// Usage: points arrive on the input channel (in_valid_i / in_stall_o), one request
// per point, and are written to the point store in load order. A point with
// final_point_i set closes the set and starts clustering. Points past the store
// capacity are dropped and reported through overflow_o on every canopy of the set.
// Each canopy leaves as one request on the output channel (out_valid_o /
// out_stall_i), in order, the last one marked by last_canopy_o.
// Loading accepts one point per cycle. Clustering runs canopy by canopy: for each
// centre, the block picks the lowest set bit of the remaining points, reads the
// centre, then reads each later stored point over the single read port, waits for
// the distance pipeline to drain and see it empty, and hands the canopy to the
// output. A centre with no later point skips the store reads. The input stalls
// from the final point until the last canopy has been handed to the output register.
// A stalled output holds its request; the block finishes at most the next canopy
// and then waits for the output register to drain.
// Reset returns the block to loading an empty set with the thresholds at their
// default values; the point store needs no clearing.
module canopy_clustering (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [cc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Point input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [cc_pkg::CoordW-1:0] coord_a_i,
  input  logic signed [cc_pkg::CoordW-1:0] coord_b_i,
  input  logic signed [cc_pkg::CoordW-1:0] coord_c_i,
  input  logic signed [cc_pkg::CoordW-1:0] coord_d_i,
  input  logic                            final_point_i,
  // Canopy output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cc_pkg::OutIdxW-1:0]      canopy_index_o,
  output logic [cc_pkg::OutIdxW-1:0]      centre_index_o,
  output logic [cc_pkg::OutMaskW-1:0]     member_mask_o,
  output logic                            last_canopy_o,
  output logic                            overflow_o
);
  import cc_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PICK,
    ST_CENTRE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [DimsW-1:0] dims_q;
  logic [DistW-1:0] loose_q;
  logic [DistW-1:0] tight_q;

  // Control state
  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 dropped_q, dropped_d;
  logic [MaxPoints-1:0] remaining_q, remaining_d;
  logic [MaxPoints-1:0] members_q, members_d;
  logic [IdxW-1:0]      centre_idx_q, centre_idx_d;
  logic [OutIdxW-1:0]   canopy_cnt_q, canopy_cnt_d;
  logic [CntW-1:0]      scan_idx_q, scan_idx_d;
  logic                 v1_q, v2_q, v3_q, v4_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [OutIdxW-1:0]   out_canopy_q, out_canopy_d;
  logic [OutIdxW-1:0]   out_centre_q, out_centre_d;
  logic [MaxPoints-1:0] out_mask_q, out_mask_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ovf_q, out_ovf_d;

  // RAM port signals
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  // Datapath registers
  logic [WordW-1:0]  centre_q;
  logic [CoordW-1:0] mag_q [MaxDims];
  logic [CoordW-1:0] mag_d [MaxDims];
  logic [SqW-1:0]    sq_q  [MaxDims];
  logic [DistW-1:0]  sum_q, sum_d;
  logic [IdxW-1:0]   idx1_q, idx2_q, idx3_q, idx4_q;

  // Helpers
  logic [DimsW-1:0]     act_dims;
  logic                 scan_issue;
  logic [MaxPoints-1:0] pick_onehot;
  logic [IdxW-1:0]      pick_idx;
  logic [MaxPoints:0]   init_full;
  logic                 out_free;

  assign ram_waddr = count_q[IdxW-1:0];
  assign ram_wdata = {coord_d_i, coord_c_i, coord_b_i, coord_a_i};

  cc_ram #(
    .Width (WordW),
    .Depth (MaxPoints)
  ) u_point_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= DimsReset;
      loose_q <= LooseReset;
      tight_q <= TightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDims:  dims_q  <= cfg_wdata_i[DimsW-1:0];
        CfgLoose: loose_q <= cfg_wdata_i;
        CfgTight: tight_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // Number of coordinates that enter the distance, clamped to one through MaxDims.
  always_comb begin
    if (dims_q == '0) begin
      act_dims = DimsW'(1);
    end else if (dims_q > DimsW'(MaxDims)) begin
      act_dims = DimsW'(MaxDims);
    end else begin
      act_dims = dims_q;
    end
  end

  // Lowest remaining point: isolate the lowest set bit, then encode it.
  assign pick_onehot = remaining_q & (~remaining_q + MaxPoints'(1));
  always_comb begin
    pick_idx = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int i = 0; i < MaxPoints; i++) begin
        if (((i >> b) & 1) == 1) begin
          pick_idx[b] = pick_idx[b] | pick_onehot[i];
        end
      end
    end
  end

  // Candidate mask for a new set, from the number of stored points.
  assign init_full  = (MaxPoints + 1)'(1) << count_d;
  assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q < count_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer next state.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dropped_d    = dropped_q;
    remaining_d  = remaining_q;
    members_d    = members_q;
    centre_idx_d = centre_idx_q;
    canopy_cnt_d = canopy_cnt_q;
    scan_idx_d   = scan_idx_q;
    out_valid_d  = out_valid_q;
    out_canopy_d = out_canopy_q;
    out_centre_d = out_centre_q;
    out_mask_d   = out_mask_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    // The receiver takes the pending canopy.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Last pipeline stage: threshold compares for one point.
    if (v4_q && remaining_q[idx4_q]) begin
      if (sum_q < loose_q) begin
        members_d[idx4_q] = 1'b1;
      end
      if (sum_q < tight_q) begin
        remaining_d[idx4_q] = 1'b0;
      end
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CntW'(MaxPoints)) begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (final_point_i) begin
            remaining_d  = init_full[MaxPoints-1:0] - MaxPoints'(1);
            canopy_cnt_d = '0;
            state_d      = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        ram_re       = 1'b1;
        ram_raddr    = pick_idx;
        centre_idx_d = pick_idx;
        members_d    = pick_onehot;
        remaining_d  = remaining_q & ~pick_onehot;
        scan_idx_d   = CntW'(pick_idx) + CntW'(1);
        state_d      = ST_CENTRE;
      end
      ST_CENTRE: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_issue) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_idx_q[IdxW-1:0];
          scan_idx_d = scan_idx_q + CntW'(1);
        end else if (!v1_q && !v2_q && !v3_q && !v4_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_canopy_d = canopy_cnt_q;
          out_centre_d = OutIdxW'(centre_idx_q);
          out_mask_d   = members_q;
          out_last_d   = (remaining_q == '0);
          out_ovf_d    = dropped_q;
          canopy_cnt_d = canopy_cnt_q + OutIdxW'(1);
          if (remaining_q == '0) begin
            count_d      = '0;
            dropped_d    = 1'b0;
            canopy_cnt_d = '0;
            state_d      = ST_LOAD;
          end else begin
            state_d = ST_PICK;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State, pipeline valids and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      remaining_q  <= '0;
      members_q    <= '0;
      centre_idx_q <= '0;
      canopy_cnt_q <= '0;
      scan_idx_q   <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_canopy_q <= '0;
      out_centre_q <= '0;
      out_mask_q   <= '0;
      out_last_q   <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      dropped_q    <= dropped_d;
      remaining_q  <= remaining_d;
      members_q    <= members_d;
      centre_idx_q <= centre_idx_d;
      canopy_cnt_q <= canopy_cnt_d;
      scan_idx_q   <= scan_idx_d;
      v1_q         <= scan_issue;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      v4_q         <= v3_q;
      out_valid_q  <= out_valid_d;
      out_canopy_q <= out_canopy_d;
      out_centre_q <= out_centre_d;
      out_mask_q   <= out_mask_d;
      out_last_q   <= out_last_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  // Stage one: coordinate magnitudes of the difference to the centre.
  always_comb begin
    for (int k = 0; k < MaxDims; k++) begin
      logic signed [CoordW:0] diff;
      diff = {ram_rdata[k*CoordW+CoordW-1], ram_rdata[k*CoordW +: CoordW]}
           - {centre_q[k*CoordW+CoordW-1], centre_q[k*CoordW +: CoordW]};
      if (DimsW'(k) >= act_dims) begin
        mag_d[k] = '0;
      end else if (diff[CoordW]) begin
        mag_d[k] = CoordW'(-diff);
      end else begin
        mag_d[k] = diff[CoordW-1:0];
      end
    end
  end

  // Stage three: sum of the squared magnitudes.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < MaxDims; k++) begin
      sum_d = sum_d + DistW'(sq_q[k]);
    end
  end

  // Distance pipeline datapath.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CENTRE) begin
      centre_q <= ram_rdata;
    end
    idx1_q <= scan_idx_q[IdxW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    for (int k = 0; k < MaxDims; k++) begin
      mag_q[k] <= mag_d[k];
      sq_q[k]  <= SqW'(mag_q[k]) * SqW'(mag_q[k]);
    end
    sum_q <= sum_d;
  end

  assign in_stall_o     = (state_q != ST_LOAD);
  assign out_valid_o    = out_valid_q;
  assign canopy_index_o = out_canopy_q;
  assign centre_index_o = out_centre_q;
  assign member_mask_o  = OutMaskW'(out_mask_q);
  assign last_canopy_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

FILE: hw/rtl/cc_checker.sv
// Port-level checker for the canopy clustering block, bound to the top level.
// Depends on cc_pkg for field widths and on canopy_clustering for the bind.
module cc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        final_point_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [cc_pkg::OutIdxW-1:0]  centre_index_o,
  input logic [cc_pkg::OutMaskW-1:0] member_mask_o,
  input logic                        last_canopy_o
);

  // A stalled canopy request stays valid and keeps its centre index and member mask.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(member_mask_o)
      && $stable(centre_index_o))
    else $error("stalled canopy request changed");

  // Closing a set stops point intake for clustering.
  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_point_i |=> in_stall_o)
    else $error("input not stalled after the final point");

  // The centre is always a member of its canopy.
  a_centre_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> member_mask_o[centre_index_o])
    else $error("centre missing from member mask");

  // After a canopy that is not the last, clustering is still under way.
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_canopy_o |=> out_valid_o || in_stall_o)
    else $error("set closed before its last canopy");

endmodule

bind canopy_clustering cc_checker u_cc_checker (.*);
